>>> rtl/sha256_byte_stream_hasher_defines.svh
// Assertion macros used by the SHA-256 hasher compression engine
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SBSH_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbsh assertion failed");
// next-cycle implication
`define SBSH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbsh assertion failed");
`else
`define SBSH_ASSERT(label, ante, cons)
`define SBSH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/sbsh_pkg.sv
// Shared types, constants and round functions of the SHA-256 hasher
`timescale 1ns / 1ps
`default_nettype none
package sbsh_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam logic [0:7][31:0] H_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// one 32-bit message word on its way from front to back
	typedef struct packed {
		logic        last;   // final word of the final block of a message
		logic [31:0] word;
	} sbsh_item_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} >> n;
		rotr = d[31:0];
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		case (t)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			6'd63: round_k = 32'hc67178f2;
			default: round_k = 32'h0;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> rtl/sha256_byte_stream_hasher.sv
// SHA-256 byte-stream hasher top level: front end, word queue, compression engine.
// Throughput: one item per cycle while the queue has room and no padding is being issued;
// the front keeps queueing bytes while the engine runs the rounds of a block.
// After the end item, padding words stream at one per cycle while the queue has room;
// the digest then follows as 8 words at one per pop.
// Reset (arst_n low, async): front idle with a zero byte count, queue empty, IV loaded.
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        has_byte,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sbsh_pkg::*;

	// words from the front toward the engine
	sbsh_item_t wr_item;
	sbsh_item_t rd_item;
	logic       wr_en;
	logic       q_full;
	logic       q_empty;
	logic       rd_en;

	// front: takes items, packs bytes, and after an end item issues the 0x80 marker,
	// zero fill and the 64-bit bit count; stalls input while padding is issued
	sbsh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.has_byte       (has_byte),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.q_push         (wr_en),
		.q_item         (wr_item),
		.q_full         (q_full)
	);

	// short queue so the front keeps taking items while the engine runs rounds
	sbsh_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_item (wr_item),
		.full    (q_full),
		.rd_en   (rd_en),
		.rd_item (rd_item),
		.empty   (q_empty)
	);

	// engine: collects 16 words, runs the rounds, folds into the chaining words and
	// presents the digest straight from them after the last block of a message
	sbsh_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (rd_item),
		.q_pop       (rd_en),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule
`default_nettype wire

>>> rtl/sbsh_front.sv
// Front end: packs bytes into big-endian words and generates message padding
`timescale 1ns / 1ps
`default_nettype none
module sbsh_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                has_byte,
	input  logic [7:0]          data_byte,
	input  logic                end_of_message,
	output logic                q_push,
	output sbsh_pkg::sbsh_item_t q_item,
	input  logic                q_full
);
	import sbsh_pkg::*;

	typedef enum logic [1:0] {
		FE_IDLE = 2'b01,
		FE_PAD  = 2'b10
	} fe_state_t;

	fe_state_t   state_q;
	logic [63:0] count_q;   // message bytes so far, wraps
	logic [31:0] part_q;    // word being assembled
	logic [3:0]  widx_q;    // word slot inside the block during padding
	logic        first_q;   // next pad word carries the 0x80 marker
	logic        final_q;   // padding is in the block that takes the length

	logic        take;
	logic [1:0]  lane;
	logic [31:0] byte_word;
	logic [31:0] part_d;
	logic [63:0] count_next;
	logic [31:0] keep_mask;
	logic [31:0] pad_first;
	logic [31:0] pad_word;
	logic        pad_last;

	assign full = (state_q == FE_PAD) || q_full;
	assign take = push && !full;
	assign lane = count_q[1:0];

	assign byte_word  = {24'h0, data_byte} << {~lane, 3'b000};
	assign part_d     = (lane == 2'd0) ? byte_word : (part_q | byte_word);
	assign count_next = count_q + {63'h0, has_byte};

	// bytes already in the word stay, the marker follows them
	assign keep_mask = ~(32'hffffffff >> {lane, 3'b000});
	assign pad_first = (part_q & keep_mask) | (32'h80000000 >> {lane, 3'b000});
	assign pad_last  = final_q && (widx_q == 4'd15);

	always_comb begin
		if (first_q) begin
			pad_word = pad_first;
		end else if (final_q && widx_q == 4'd14) begin
			pad_word = count_q[60:29];
		end else if (pad_last) begin
			pad_word = {count_q[28:0], 3'b000};
		end else begin
			pad_word = 32'h0;
		end
	end

	always_comb begin
		q_push      = 1'b0;
		q_item.last = 1'b0;
		q_item.word = part_d;
		case (state_q)
			FE_IDLE: begin
				q_push = take && has_byte && (lane == 2'd3);
			end
			FE_PAD: begin
				q_push      = !q_full;
				q_item.last = pad_last;
				q_item.word = pad_word;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_IDLE;
			count_q <= 64'h0;
			widx_q  <= 4'd0;
			first_q <= 1'b0;
			final_q <= 1'b0;
		end else begin
			case (state_q)
				FE_IDLE: begin
					if (take) begin
						count_q <= count_next;
						if (end_of_message) begin
							state_q <= FE_PAD;
							first_q <= 1'b1;
							widx_q  <= count_next[5:2];
							final_q <= ~&count_next[5:3];
						end
					end
				end
				FE_PAD: begin
					if (!q_full) begin
						first_q <= 1'b0;
						widx_q  <= widx_q + 4'd1;
						if (widx_q == 4'd15) begin
							final_q <= 1'b1;
						end
						if (pad_last) begin
							state_q <= FE_IDLE;
							count_q <= 64'h0;
						end
					end
				end
				default: begin
					state_q <= FE_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FE_IDLE && take && has_byte) begin
			part_q <= part_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/sbsh_fifo.sv
// Short word queue between the front end and the compression engine
`timescale 1ns / 1ps
`default_nettype none
module sbsh_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  sbsh_pkg::sbsh_item_t wr_item,
	output logic                 full,
	input  logic                 rd_en,
	output sbsh_pkg::sbsh_item_t rd_item,
	output logic                 empty
);
	import sbsh_pkg::*;

	sbsh_item_t            mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule
`default_nettype wire

>>> rtl/sbsh_core.sv
// Compression engine: schedule window, one round per cycle, digest output
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_byte_stream_hasher_defines.svh"
module sbsh_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  sbsh_pkg::sbsh_item_t q_item,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [31:0]          digest_word,
	output logic [2:0]           word_index,
	output logic                 last_word
);
	import sbsh_pkg::*;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_ADD   = 4'b0100,
		ST_OUT   = 4'b1000
	} core_state_t;

	core_state_t state_q;
	logic [31:0] h_q [8];    // chaining words
	logic [31:0] v_q [8];    // working variables a..h
	logic [31:0] w_q [16];   // schedule window, w_q[0] is W[t]
	logic [3:0]  ld_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        last_q;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;
	logic        take_out;

	assign q_pop       = (state_q == ST_LOAD) && !q_empty;
	assign empty       = (state_q != ST_OUT);
	assign take_out    = pop && !empty;
	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

	assign t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ round_k(rnd_q) + w_q[0];
	assign t2 = big_sigma0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			ld_q    <= 4'd0;
			rnd_q   <= 6'd0;
			idx_q   <= 3'd0;
			last_q  <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						ld_q <= ld_q + 4'd1;
						if (ld_q == 4'd15) begin
							last_q  <= q_item.last;
							rnd_q   <= 6'd0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					idx_q   <= 3'd0;
					state_q <= last_q ? ST_OUT : ST_LOAD;
				end
				ST_OUT: begin
					if (take_out) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= ST_LOAD;
							for (int i = 0; i < 8; i++) begin
								h_q[i] <= H_INIT[i];
							end
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// datapath registers: window shifts on load and on every round
	always_ff @(posedge clk) begin
		if (q_pop) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= q_item.word;
			if (ld_q == 4'd15) begin
				for (int i = 0; i < 8; i++) begin
					v_q[i] <= h_q[i];
				end
			end
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	`SBSH_ASSERT_NEXT(a_round_start, state_q == ST_LOAD && q_pop && ld_q == 4'd15, state_q == ST_ROUND && rnd_q == 6'd0)
	`SBSH_ASSERT(a_load_count_idle, state_q != ST_LOAD, ld_q == 4'd0)
	`SBSH_ASSERT_NEXT(a_out_hold, state_q == ST_OUT && !pop, state_q == ST_OUT && $stable(idx_q))
	`SBSH_ASSERT_NEXT(a_reinit, state_q == ST_OUT && pop && idx_q == 3'd7, state_q == ST_LOAD && h_q[0] == H_INIT[0])

endmodule
`default_nettype wire
